FILE: hw/rtl/gcd_pkg.sv
// ============================================================================
// gcd_pkg - great circle distance shared types and constants
// Fixed-point formats, CORDIC tables and the pipeline latency of the unit.
// ============================================================================
package gcd_pkg;

    // Coordinate scaling: degrees times 2^COORD_FRAC_BITS
    localparam int COORD_FRAC_BITS = 16;

    // Angles in units of 2^-(COORD_FRAC_BITS+1) degree; a quarter is 90 degrees
    localparam int QUARTER = 180 << COORD_FRAC_BITS;
    localparam int TURN    = 4 * QUARTER;

    // Shift that takes r * (pi/180 in Q60) to radians in Q48
    localparam int Z_SHIFT = 13 + COORD_FRAC_BITS;

    localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

    // Fixed-point types
    typedef logic signed [25:0] angle_t;   // reduced input angle
    typedef logic signed [31:0] q30_t;     // sine / cosine in Q30
    typedef logic signed [43:0] vec_t;     // CORDIC vector in Q40
    typedef logic signed [51:0] zang_t;    // CORDIC angle in Q48

    // Unsigned quotient by shift and subtract, elaboration use only
    function automatic logic [63:0] udiv_c(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int k = 63; k >= 0; k--)
        begin
            rem = {rem[63:0], n[k]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // pi in Q60 by Machin's series
    function automatic logic [63:0] pi_q60();
        logic [63:0] p;
        logic [63:0] s5;
        logic [63:0] s239;
        logic [63:0] t;
        s5   = '0;
        s239 = '0;
        p    = udiv_c(ONE_Q60, 64'd5);
        for (int k = 0; k < 64; k++)
        begin
            if (p != 0)
            begin
                t = udiv_c(p, 64'(2 * k + 1));
                if (k[0])
                    s5 = s5 - t;
                else
                    s5 = s5 + t;
                p = udiv_c(udiv_c(p, 64'd5), 64'd5);
            end
        end
        p = udiv_c(ONE_Q60, 64'd239);
        for (int k = 0; k < 64; k++)
        begin
            if (p != 0)
            begin
                t = udiv_c(p, 64'(2 * k + 1));
                if (k[0])
                    s239 = s239 - t;
                else
                    s239 = s239 + t;
                p = udiv_c(udiv_c(p, 64'd239), 64'd239);
            end
        end
        return (s5 << 4) - (s239 << 2);
    endfunction

    // atan(2^-i) in Q60
    function automatic logic [63:0] atan_pow2_q60(input int i);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] t;
        sum = '0;
        p   = ONE_Q60 >> i;
        for (int k = 0; k < 64; k++)
        begin
            if (p != 0)
            begin
                t = udiv_c(p, 64'(2 * k + 1));
                if (k[0])
                    sum = sum - t;
                else
                    sum = sum + t;
                p = p >> (2 * i);
            end
        end
        return sum;
    endfunction

    // CORDIC step angle in Q48
    function automatic zang_t atan_q48(input int i);
        logic [63:0] v;
        if (i == 0)
            v = pi_q60() >> 2;
        else
            v = atan_pow2_q60(i);
        return zang_t'((v + (64'd1 << 11)) >> 12);
    endfunction

    // Square root rounded to nearest, elaboration use only
    function automatic logic [63:0] isqrt_round_c(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (rem > res)
            res = res + 64'd1;
        return res;
    endfunction

    // CORDIC gain in Q40 for the given number of stages
    function automatic vec_t cordic_gain_q40(input int stages);
        logic [63:0] k2;
        k2 = 64'd1 << 62;
        for (int i = 0; i < stages; i++)
        begin
            if (2 * i < 63)
                k2 = k2 - udiv_c(k2, (64'd1 << (2 * i)) + 64'd1);
        end
        return vec_t'(isqrt_round_c(k2) << 9);
    endfunction

    // pi/180 in Q60, split for two narrow multipliers
    localparam logic [63:0] PI_PER_DEG_Q60 = (pi_q60() + 64'd90) / 64'd180;
    localparam logic [31:0] PPD_LO = PI_PER_DEG_Q60[31:0];
    localparam logic [22:0] PPD_HI = PI_PER_DEG_Q60[54:32];

    // Round a Q40 vector component to Q30 and clamp to +-1
    function automatic q30_t round_clamp(input vec_t v);
        vec_t                t;
        logic signed [33:0]  n;
        t = (v + vec_t'(512)) >>> 10;
        n = t[33:0];
        if (n > 34'sd1073741824)
            return q30_t'(32'sd1073741824);
        if (n < -34'sd1073741824)
            return q30_t'(-32'sd1073741824);
        return n[31:0];
    endfunction

    // Cycles from accepted request to result strobe
    function automatic int gcd_latency(input int stages);
        return 82 + 2 * stages;
    endfunction

endpackage

FILE: hw/rtl/great_circle_distance_unit.sv
// ============================================================================
// great_circle_distance_unit - haversine distance between two points
// Four sine/cosine pipelines, haversine term, two roots, CORDIC arcsine and
// scaling by the sphere radius, all in one fully pipelined datapath.
// ============================================================================
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  request  | start (busy is 0)    | first/second latitude, first/second longitude
//  result   | done, one cycle      | arc_distance
//  config   | cfg_we               | cfg_wdata (sphere radius)
//
//  One request per cycle; each passes two CORDIC chains of TRIG_STAGES steps and
//  two 33-stage square roots.
//  busy stays low; the pipeline never stalls and the result side cannot hold off.
//  rst_n clears all valid bits and loads the radius with 6371.
//
module great_circle_distance_unit
    import gcd_pkg::*;
#(
    parameter int TRIG_STAGES = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] first_latitude,
    input  logic signed [24:0] first_longitude,
    input  logic signed [23:0] second_latitude,
    input  logic signed [24:0] second_longitude,
    input  logic               cfg_we,
    input  logic        [12:0] cfg_wdata,
    output logic               done,
    output logic        [24:0] arc_distance
);

    localparam int    ROOT_DLY = 35;
    localparam int    PROD_STG = 6;

    // configuration
    logic [12:0] sphere_radius_reg;
    logic [22:0] radius_milli;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sphere_radius_reg <= 13'd6371;
        else if (cfg_we)
            sphere_radius_reg <= cfg_wdata;
    end

    assign radius_milli = sphere_radius_reg * 10'd1000;
    assign busy         = 1'b0;

    // request stage: angle arguments
    logic   in_vld_reg;
    angle_t ang_reg [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        ang_reg[0] <= angle_t'({first_latitude[23], first_latitude, 1'b0});
        ang_reg[1] <= angle_t'({second_latitude[23], second_latitude, 1'b0});
        ang_reg[2] <= angle_t'(second_latitude) - angle_t'(first_latitude);
        ang_reg[3] <= angle_t'(second_longitude) - angle_t'(first_longitude);
    end

    // cos(lat1), cos(lat2), sin(dlat/2), sin(dlon/2)
    logic [3:0] sc_vld;
    q30_t       sc_val [0:3];

    for (genvar u = 0; u < 4; u++)
    begin : g_sc
        gcd_sincos #(
            .STAGES    (TRIG_STAGES)
        ) u_sincos (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (in_vld_reg),
            .in_angle  (ang_reg[u]),
            .use_cos   (u < 2),
            .out_valid (sc_vld[u]),
            .out_value (sc_val[u])
        );
    end

    // haversine term
    logic [PROD_STG-1:0] p_vld_reg;
    logic [30:0]         c1_mag;
    logic [30:0]         c2_mag;
    logic [61:0]         c12_prod;
    logic signed [63:0]  sq_prod;
    logic [61:0]         c12_reg;
    logic                n12_reg;
    logic [61:0]         sq_reg [1:5];
    q30_t                slon_reg [1:4];
    logic [61:0]         c12_rnd;
    q30_t                cp_reg;
    logic [30:0]         cp_mag;
    logic [30:0]         slon_mag;
    logic [61:0]         u_prod;
    logic [61:0]         u_reg;
    logic                nu_reg;
    logic [61:0]         u_rnd;
    q30_t                uq_reg;
    logic signed [63:0]  us_prod;
    logic signed [63:0]  us_reg;
    logic signed [63:0]  a_sum;
    logic [60:0]         a_next;
    logic [60:0]         a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= '0;
        else
            p_vld_reg <= {p_vld_reg[PROD_STG-2:0], &sc_vld};
    end

    assign c1_mag   = sc_val[0][31] ? 31'(-sc_val[0]) : sc_val[0][30:0];
    assign c2_mag   = sc_val[1][31] ? 31'(-sc_val[1]) : sc_val[1][30:0];
    assign c12_prod = c1_mag * c2_mag;
    assign sq_prod  = sc_val[2] * sc_val[2];
    assign c12_rnd  = c12_reg + (62'd1 << 29);
    assign cp_mag   = cp_reg[31] ? 31'(-cp_reg) : cp_reg[30:0];
    assign slon_mag = slon_reg[2][31] ? 31'(-slon_reg[2]) : slon_reg[2][30:0];
    assign u_prod   = cp_mag * slon_mag;
    assign u_rnd    = u_reg + (62'd1 << 29);
    assign us_prod  = uq_reg * slon_reg[4];
    assign a_sum    = $signed({2'b00, sq_reg[5]}) + us_reg;

    // clamp to [0, 1]
    always_comb
    begin
        priority if (a_sum < 0)
            a_next = '0;
        else if (a_sum > $signed(ONE_Q60))
            a_next = 61'(ONE_Q60);
        else
            a_next = a_sum[60:0];
    end

    always_ff @(posedge clk)
    begin
        c12_reg     <= c12_prod;
        n12_reg     <= sc_val[0][31] ^ sc_val[1][31];
        sq_reg[1]   <= sq_prod[61:0];
        slon_reg[1] <= sc_val[3];
        cp_reg      <= n12_reg ? -$signed({1'b0, c12_rnd[60:30]})
                               :  $signed({1'b0, c12_rnd[60:30]});
        sq_reg[2]   <= sq_reg[1];
        slon_reg[2] <= slon_reg[1];
        u_reg       <= u_prod;
        nu_reg      <= cp_reg[31] ^ slon_reg[2][31];
        sq_reg[3]   <= sq_reg[2];
        slon_reg[3] <= slon_reg[2];
        uq_reg      <= nu_reg ? -$signed({1'b0, u_rnd[60:30]})
                              :  $signed({1'b0, u_rnd[60:30]});
        sq_reg[4]   <= sq_reg[3];
        slon_reg[4] <= slon_reg[3];
        us_reg      <= us_prod;
        sq_reg[5]   <= sq_reg[4];
        a_reg       <= a_next;
    end

    // sqrt(a)
    logic        r1_vld;
    logic [30:0] root;

    gcd_isqrt u_sqrt_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_vld_reg[PROD_STG-1]),
        .in_value  (a_reg),
        .out_valid (r1_vld),
        .out_root  (root)
    );

    // 1 - root^2
    logic [1:0]  q_vld_reg;
    logic [61:0] rr_prod;
    logic [61:0] rr_reg;
    logic [60:0] t_reg;
    logic [30:0] root_dly_reg [1:ROOT_DLY];

    assign rr_prod = root * root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_vld_reg <= '0;
        else
            q_vld_reg <= {q_vld_reg[0], r1_vld};
    end

    always_ff @(posedge clk)
    begin
        rr_reg          <= rr_prod;
        t_reg           <= 61'(ONE_Q60 - 64'(rr_reg));
        root_dly_reg[1] <= root;
        for (int k = 2; k <= ROOT_DLY; k++)
            root_dly_reg[k] <= root_dly_reg[k-1];
    end

    logic        r2_vld;
    logic [30:0] rest;

    gcd_isqrt u_sqrt_rest (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_vld_reg[1]),
        .in_value  (t_reg),
        .out_valid (r2_vld),
        .out_root  (rest)
    );

    // atan2(root, rest) by CORDIC vectoring
    logic [TRIG_STAGES-1:0] v_vld_reg;
    vec_t                   vx_reg [0:TRIG_STAGES-1];
    vec_t                   vy_reg [0:TRIG_STAGES-1];
    zang_t                  vz_reg [0:TRIG_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_vld_reg <= '0;
        else
            v_vld_reg <= {v_vld_reg[TRIG_STAGES-2:0], r2_vld};
    end

    for (genvar k = 0; k < TRIG_STAGES; k++)
    begin : g_vec
        localparam zang_t ATAN = atan_q48(k);
        vec_t  xi;
        vec_t  yi;
        zang_t zi;
        if (k == 0)
        begin : g_first
            assign xi = vec_t'({rest, 10'd0});
            assign yi = vec_t'({root_dly_reg[ROOT_DLY], 10'd0});
            assign zi = '0;
        end
        else
        begin : g_next
            assign xi = vx_reg[k-1];
            assign yi = vy_reg[k-1];
            assign zi = vz_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            if (yi >= 0)
            begin
                vx_reg[k] <= xi + (yi >>> k);
                vy_reg[k] <= yi - (xi >>> k);
                vz_reg[k] <= zi + ATAN;
            end
            else
            begin
                vx_reg[k] <= xi - (yi >>> k);
                vy_reg[k] <= yi + (xi >>> k);
                vz_reg[k] <= zi - ATAN;
            end
        end
    end

    // distance = 2 * angle * radius * 1000, rounded from Q48
    logic [1:0]  d_vld_reg;
    zang_t       ang;
    logic [49:0] ang2;
    logic [54:0] dlo_prod;
    logic [40:0] dhi_prod;
    logic [54:0] dlo_reg;
    logic [40:0] dhi_reg;
    logic [73:0] dist_sum;
    logic [24:0] dist_reg;

    assign ang      = vz_reg[TRIG_STAGES-1][51] ? '0 : vz_reg[TRIG_STAGES-1];
    assign ang2     = {ang[48:0], 1'b0};
    assign dlo_prod = ang2[31:0] * radius_milli;
    assign dhi_prod = ang2[49:32] * radius_milli;
    assign dist_sum = {1'b0, dhi_reg, 32'd0} + 74'(dlo_reg) + (74'd1 << 47);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= '0;
        else
            d_vld_reg <= {d_vld_reg[0], v_vld_reg[TRIG_STAGES-1]};
    end

    always_ff @(posedge clk)
    begin
        dlo_reg  <= dlo_prod;
        dhi_reg  <= dhi_prod;
        dist_reg <= dist_sum[72:48];
    end

    assign done         = d_vld_reg[1];
    assign arc_distance = dist_reg;

endmodule

FILE: hw/rtl/gcd_sincos.sv
// ============================================================================
// gcd_sincos - pipelined sine or cosine
// Range reduction to a quadrant, Q48 radians, CORDIC rotation, quadrant fold.
// ============================================================================
module gcd_sincos
    import gcd_pkg::*;
#(
    parameter int STAGES = 32
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  angle_t in_angle,
    input  logic   use_cos,
    output logic   out_valid,
    output q30_t   out_value
);

    localparam int   LAT    = STAGES + 5;
    localparam vec_t GAIN   = cordic_gain_q40(STAGES);
    localparam logic signed [26:0] TURN_S = 27'(TURN);
    localparam logic [25:0] Q1 = 26'(QUARTER);
    localparam logic [25:0] Q2 = 26'(2 * QUARTER);
    localparam logic [25:0] Q3 = 26'(3 * QUARTER);

    logic [LAT-1:0] vld_reg;
    logic [25:0]    m_reg;
    logic [25:0]    m_next;
    logic [24:0]    r_reg;
    logic [24:0]    r_next;
    logic [1:0]     q_next;
    logic [1:0]     q2_reg;
    logic [1:0]     q3_reg;
    logic [1:0]     q4_reg;
    logic [56:0]    plo_reg;
    logic [47:0]    phi_reg;
    logic [56:0]    plo_next;
    logic [47:0]    phi_next;
    logic [79:0]    zsum;
    zang_t          z0_reg;
    vec_t           x_reg [0:STAGES-1];
    vec_t           y_reg [0:STAGES-1];
    zang_t          z_reg [0:STAGES-1];
    logic [1:0]     qr_reg [0:STAGES-1];
    q30_t           c_val;
    q30_t           s_val;
    q30_t           sn;
    q30_t           cs;
    q30_t           out_reg;

    // valid travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // wrap into one turn
    assign m_next = in_angle[25] ? 26'($signed({in_angle[25], in_angle}) + TURN_S)
                                 : 26'(in_angle);

    // quadrant and rest
    always_comb
    begin
        priority if (m_reg >= Q3)
        begin
            q_next = 2'd3;
            r_next = 25'(m_reg - Q3);
        end
        else if (m_reg >= Q2)
        begin
            q_next = 2'd2;
            r_next = 25'(m_reg - Q2);
        end
        else if (m_reg >= Q1)
        begin
            q_next = 2'd1;
            r_next = 25'(m_reg - Q1);
        end
        else
        begin
            q_next = 2'd0;
            r_next = m_reg[24:0];
        end
    end

    // degrees to radians, two partial products
    assign plo_next = r_reg * PPD_LO;
    assign phi_next = r_reg * PPD_HI;

    // rounded sum of the partial products
    assign zsum = {phi_reg, 32'd0} + 80'(plo_reg) + (80'd1 << (Z_SHIFT - 1));

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        r_reg   <= r_next;
        q2_reg  <= q_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        q3_reg  <= q2_reg;
        z0_reg  <= zang_t'(zsum >> Z_SHIFT);
        q4_reg  <= q3_reg;
    end

    // CORDIC rotation, one step per stage
    for (genvar k = 0; k < STAGES; k++)
    begin : g_rot
        localparam zang_t ATAN = atan_q48(k);
        vec_t        xi;
        vec_t        yi;
        zang_t       zi;
        logic [1:0]  qi;
        if (k == 0)
        begin : g_first
            assign xi = GAIN;
            assign yi = '0;
            assign zi = z0_reg;
            assign qi = q4_reg;
        end
        else
        begin : g_next
            assign xi = x_reg[k-1];
            assign yi = y_reg[k-1];
            assign zi = z_reg[k-1];
            assign qi = qr_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            if (zi >= 0)
            begin
                x_reg[k] <= xi - (yi >>> k);
                y_reg[k] <= yi + (xi >>> k);
                z_reg[k] <= zi - ATAN;
            end
            else
            begin
                x_reg[k] <= xi + (yi >>> k);
                y_reg[k] <= yi - (xi >>> k);
                z_reg[k] <= zi + ATAN;
            end
            qr_reg[k] <= qi;
        end
    end

    // round, clamp and fold by quadrant
    assign c_val = round_clamp(x_reg[STAGES-1]);
    assign s_val = round_clamp(y_reg[STAGES-1]);

    always_comb
    begin
        unique case (qr_reg[STAGES-1])
            2'd0:
            begin
                sn = s_val;
                cs = c_val;
            end
            2'd1:
            begin
                sn = c_val;
                cs = -s_val;
            end
            2'd2:
            begin
                sn = -s_val;
                cs = -c_val;
            end
            default:
            begin
                sn = -c_val;
                cs = s_val;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_reg <= use_cos ? cs : sn;
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_value = out_reg;

endmodule

FILE: hw/rtl/gcd_isqrt.sv
// ============================================================================
// gcd_isqrt - pipelined square root
// One result bit per stage, then round to nearest.
// ============================================================================
module gcd_isqrt
    import gcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [60:0] in_value,
    output logic        out_valid,
    output logic [30:0] out_root
);

    localparam int STEPS = 32;

    logic [STEPS:0] vld_reg;
    logic [63:0]    rem_reg [0:STEPS-1];
    logic [63:0]    res_reg [0:STEPS-1];
    logic [30:0]    root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[STEPS-1:0], in_valid};
    end

    // restoring root, one step per stage
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
        logic [63:0] remi;
        logic [63:0] resi;
        logic [63:0] trial;
        if (k == 0)
        begin : g_first
            assign remi = 64'(in_value);
            assign resi = '0;
        end
        else
        begin : g_next
            assign remi = rem_reg[k-1];
            assign resi = res_reg[k-1];
        end
        assign trial = resi + BITV;
        always_ff @(posedge clk)
        begin
            if (remi >= trial)
            begin
                rem_reg[k] <= remi - trial;
                res_reg[k] <= (resi >> 1) + BITV;
            end
            else
            begin
                rem_reg[k] <= remi;
                res_reg[k] <= resi >> 1;
            end
        end
    end

    // round to nearest
    always_ff @(posedge clk)
    begin
        if (rem_reg[STEPS-1] > res_reg[STEPS-1])
            root_reg <= 31'(res_reg[STEPS-1] + 64'd1);
        else
            root_reg <= res_reg[STEPS-1][30:0];
    end

    assign out_valid = vld_reg[STEPS];
    assign out_root  = root_reg;

endmodule

FILE: hw/rtl/gcd_checker.sv
// ============================================================================
// gcd_checker - port-level checks for great_circle_distance_unit
// Fixed latency from request to result, nothing dropped or invented.
// ============================================================================
module gcd_checker
    import gcd_pkg::*;
#(
    parameter int STAGES = 32
)
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    localparam int LAT = gcd_latency(STAGES);

    // the pipeline always takes a request
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised on a stall-free pipeline");

    // every request gets its result after the fixed latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after request");

    // no result without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching request");

endmodule

bind great_circle_distance_unit gcd_checker #(
    .STAGES (TRIG_STAGES)
) u_gcd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done)
);
